// File: src/pl_pkg.sv
// Shared types, widths and helpers for the positional list engine.
// Used by every module under src except pl_ram; depends on nothing else.
package pl_pkg;

   localparam int CAPACITY    = 32;
   localparam int DATA_WIDTH  = 32;
   localparam int IDX_W       = $clog2(CAPACITY);
   localparam int LEN_W       = $clog2(CAPACITY + 1);
   localparam int KIND_W      = 3;
   localparam int POS_W       = 7;
   localparam int VAL_W       = 32;
   localparam int FIND_W      = 7;
   localparam int SIZE_W      = 7;
   localparam int REQ_TDATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = VAL_W + FIND_W + SIZE_W;
   localparam int RSP_TDATA_W = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_FIELD_W;

   typedef logic [DATA_WIDTH-1:0] word_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT    = 3'd0,
      KIND_DELETE    = 3'd1,
      KIND_OVERWRITE = 3'd2,
      KIND_READ      = 3'd3,
      KIND_FIND      = 3'd4,
      KIND_CLEAR     = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_DRAIN,
      ST_WRITE,
      ST_READ,
      ST_READ_DATA,
      ST_FIND,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              status;
      logic [VAL_W-1:0]  read_value;
      logic [FIND_W-1:0] found_index;
      logic [SIZE_W-1:0] list_size;
   } result_type;

   function automatic word_type to_word(input logic [VAL_W-1:0] v);
      logic signed [VAL_W-1:0] sv;
      sv = signed'(v);
      return word_type'(sv);
   endfunction

   function automatic logic [VAL_W-1:0] from_word(input word_type w);
      logic signed [DATA_WIDTH-1:0] sw;
      sw = signed'(w);
      return VAL_W'(sw);
   endfunction

endpackage

// File: src/pl_ram.sv
// Entry store: one write port, one read port with registered read data.
// Generic; no package dependency.
module pl_ram #(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// File: src/pl_core.sv
// Request sequencer: decodes a request, steps the entry store one entry per
// cycle for shifts and searches, and holds the result. Uses pl_pkg, pl_ram.
module pl_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [pl_pkg::KIND_W-1:0]    req_kind,
   input  logic [pl_pkg::POS_W-1:0]     req_pos,
   input  logic [pl_pkg::VAL_W-1:0]     req_value,
   output logic                         done_valid,
   input  logic                         done_ready,
   output pl_pkg::result_type           result
);

   pl_pkg::state_type                state_ff, state_in;
   logic                             up_ff, up_in;
   logic                             pend_ff, pend_in;
   logic [pl_pkg::IDX_W-1:0]         src_ff, src_in;
   logic [pl_pkg::IDX_W-1:0]         pend_addr_ff, pend_addr_in;
   logic [pl_pkg::IDX_W-1:0]         at_ff, at_in;
   logic [pl_pkg::IDX_W-1:0]         last_ff, last_in;
   logic [pl_pkg::LEN_W-1:0]         len_ff, len_in;
   pl_pkg::word_type                 value_ff, value_in;
   logic                             status_ff, status_in;
   logic [pl_pkg::VAL_W-1:0]         rdval_ff, rdval_in;
   logic [pl_pkg::FIND_W-1:0]        found_ff, found_in;

   logic                             wr_en;
   logic [pl_pkg::IDX_W-1:0]         wr_addr;
   pl_pkg::word_type                 wr_data;
   pl_pkg::word_type                 rd_data;
   logic [pl_pkg::IDX_W-1:0]         shift_addr;

   pl_pkg::kind_type                 kind;
   logic [pl_pkg::POS_W-1:0]         len_ext;
   logic                             pos_neg;
   logic                             pos_m1;
   logic                             in_list;
   logic                             ins_ok;
   logic [pl_pkg::IDX_W-1:0]         ins_at;
   logic [pl_pkg::IDX_W-1:0]         pos_idx;
   logic [pl_pkg::IDX_W-1:0]         len_last;
   logic                             hit;

   pl_ram #(
      .DEPTH (pl_pkg::CAPACITY),
      .WIDTH (pl_pkg::DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (src_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      kind     = pl_pkg::kind_type'(req_kind);
      len_ext  = pl_pkg::POS_W'(len_ff);
      pos_neg  = req_pos[pl_pkg::POS_W-1];
      pos_m1   = (req_pos == '1);
      in_list  = !pos_neg && (req_pos < len_ext);
      ins_ok   = (len_ff < pl_pkg::LEN_W'(pl_pkg::CAPACITY)) &&
                 (pos_m1 || (!pos_neg && (req_pos <= len_ext)));
      ins_at   = pos_m1 ? pl_pkg::IDX_W'(len_ff) : pl_pkg::IDX_W'(req_pos);
      pos_idx  = pl_pkg::IDX_W'(req_pos);
      len_last = pl_pkg::IDX_W'(len_ff - pl_pkg::LEN_W'(1));
      hit      = pend_ff && (rd_data == value_ff);
      shift_addr = up_ff ? pend_addr_ff + pl_pkg::IDX_W'(1)
                         : pend_addr_ff - pl_pkg::IDX_W'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pl_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (kind)
                  pl_pkg::KIND_INSERT: begin
                     if (!ins_ok) begin
                        state_in = pl_pkg::ST_DONE;
                     end else if (pl_pkg::LEN_W'(ins_at) == len_ff) begin
                        state_in = pl_pkg::ST_WRITE;
                     end else begin
                        state_in = pl_pkg::ST_SHIFT;
                     end
                  end
                  pl_pkg::KIND_DELETE: begin
                     if (!in_list || pos_idx == len_last) begin
                        state_in = pl_pkg::ST_DONE;
                     end else begin
                        state_in = pl_pkg::ST_SHIFT;
                     end
                  end
                  pl_pkg::KIND_OVERWRITE: begin
                     state_in = in_list ? pl_pkg::ST_WRITE : pl_pkg::ST_DONE;
                  end
                  pl_pkg::KIND_READ: begin
                     state_in = in_list ? pl_pkg::ST_READ : pl_pkg::ST_DONE;
                  end
                  pl_pkg::KIND_FIND: begin
                     state_in = (len_ff == '0) ? pl_pkg::ST_DONE : pl_pkg::ST_FIND;
                  end
                  default: state_in = pl_pkg::ST_DONE;
               endcase
            end
         end
         pl_pkg::ST_SHIFT: begin
            if (src_ff == last_ff) begin
               state_in = pl_pkg::ST_DRAIN;
            end
         end
         pl_pkg::ST_DRAIN:     state_in = up_ff ? pl_pkg::ST_WRITE : pl_pkg::ST_DONE;
         pl_pkg::ST_WRITE:     state_in = pl_pkg::ST_DONE;
         pl_pkg::ST_READ:      state_in = pl_pkg::ST_READ_DATA;
         pl_pkg::ST_READ_DATA: state_in = pl_pkg::ST_DONE;
         pl_pkg::ST_FIND: begin
            if (hit || (pend_ff && pend_addr_ff == last_ff)) begin
               state_in = pl_pkg::ST_DONE;
            end
         end
         pl_pkg::ST_DONE: begin
            if (done_ready) begin
               state_in = pl_pkg::ST_IDLE;
            end
         end
         default: state_in = pl_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      up_in        = up_ff;
      pend_in      = 1'b0;
      src_in       = src_ff;
      pend_addr_in = pend_addr_ff;
      at_in        = at_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      rdval_in     = rdval_ff;
      found_in     = found_ff;
      wr_en        = 1'b0;
      wr_addr      = shift_addr;
      wr_data      = rd_data;
      unique case (state_ff)
         pl_pkg::ST_IDLE: begin
            if (req_valid) begin
               up_in     = (kind == pl_pkg::KIND_INSERT);
               value_in  = pl_pkg::to_word(req_value);
               status_in = 1'b0;
               rdval_in  = '0;
               found_in  = '0;
               unique case (kind)
                  pl_pkg::KIND_INSERT: begin
                     status_in = !ins_ok;
                     at_in     = ins_at;
                     src_in    = len_last;
                     last_in   = ins_at;
                  end
                  pl_pkg::KIND_DELETE: begin
                     status_in = !in_list;
                     src_in    = pos_idx + pl_pkg::IDX_W'(1);
                     last_in   = len_last;
                     if (in_list && pos_idx == len_last) begin
                        len_in = len_ff - pl_pkg::LEN_W'(1);
                     end
                  end
                  pl_pkg::KIND_OVERWRITE: begin
                     status_in = !in_list;
                     at_in     = pos_idx;
                  end
                  pl_pkg::KIND_READ: begin
                     status_in = !in_list;
                     src_in    = pos_idx;
                     rdval_in  = in_list ? '0 : '1;
                  end
                  pl_pkg::KIND_FIND: begin
                     src_in   = '0;
                     last_in  = len_last;
                     found_in = '1;
                  end
                  pl_pkg::KIND_CLEAR: begin
                     len_in = '0;
                  end
                  default: status_in = 1'b1;
               endcase
            end
         end
         pl_pkg::ST_SHIFT: begin
            pend_in      = 1'b1;
            pend_addr_in = src_ff;
            src_in       = up_ff ? src_ff - pl_pkg::IDX_W'(1) : src_ff + pl_pkg::IDX_W'(1);
            wr_en        = pend_ff;
         end
         pl_pkg::ST_DRAIN: begin
            wr_en = 1'b1;
            if (!up_ff) begin
               len_in = len_ff - pl_pkg::LEN_W'(1);
            end
         end
         pl_pkg::ST_WRITE: begin
            wr_en   = 1'b1;
            wr_addr = at_ff;
            wr_data = value_ff;
            if (up_ff) begin
               len_in = len_ff + pl_pkg::LEN_W'(1);
            end
         end
         pl_pkg::ST_READ_DATA: begin
            rdval_in = pl_pkg::from_word(rd_data);
         end
         pl_pkg::ST_FIND: begin
            pend_in      = 1'b1;
            pend_addr_in = src_ff;
            src_in       = src_ff + pl_pkg::IDX_W'(1);
            if (hit) begin
               found_in = pl_pkg::FIND_W'(pend_addr_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pl_pkg::ST_IDLE;
         len_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff   <= len_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      up_ff        <= up_in;
      src_ff       <= src_in;
      pend_addr_ff <= pend_addr_in;
      at_ff        <= at_in;
      last_ff      <= last_in;
      value_ff     <= value_in;
      status_ff    <= status_in;
      rdval_ff     <= rdval_in;
      found_ff     <= found_in;
   end

   assign req_ready  = (state_ff == pl_pkg::ST_IDLE);
   assign done_valid = (state_ff == pl_pkg::ST_DONE);
   assign result     = '{status:      status_ff,
                         read_value:  rdval_ff,
                         found_index: found_ff,
                         list_size:   pl_pkg::SIZE_W'(len_ff)};

endmodule

// File: src/positional_list_engine.sv
// Top level of the positional list engine: stream ports and result register.
// Uses pl_pkg and pl_core (which holds pl_ram).
//
// An ordered list of up to CAPACITY signed words, addressed by position.
// Request channel req_*: one word per request; tuser carries the kind
// (insert, delete, overwrite, read, find, clear), tdata the position and value.
// Response channel rsp_*: exactly one word per request, in request order;
// tuser is the fail status, tdata carries read value, found index, list size.
// Clear, failed requests and delete of the last entry go straight from idle
// to the done state; insert at the head of a list one short of full and find
// with no match in a full list take longest from acceptance until the
// response word can be taken. Shifts and searches step the entry store one
// entry per cycle, so their cost grows with the length of the list.
// One request is in flight at a time: req_tready is low from acceptance until
// the result moves into the response register. A finished response waits in
// that register while the next request is taken; if the receiver stalls,
// the following result holds inside the core until the register frees.
// Reset empties the list and drops any pending response; the entry store
// itself is not cleared and needs no sweep.
module positional_list_engine (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [pl_pkg::KIND_W-1:0]      req_tuser,  // kind
   input  logic [pl_pkg::REQ_TDATA_W-1:0] req_tdata,  // position, value, zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic                           rsp_tuser,  // status
   output logic [pl_pkg::RSP_TDATA_W-1:0] rsp_tdata   // read_value, found_index,
                                                      // list_size, zero pad
);

   logic               done_valid;
   logic               done_ready;
   pl_pkg::result_type result;
   logic               rsp_valid_ff, rsp_valid_in;
   pl_pkg::result_type rsp_data_ff, rsp_data_in;

   pl_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_pos    (req_tdata[pl_pkg::POS_W-1:0]),
      .req_value  (req_tdata[pl_pkg::POS_W +: pl_pkg::VAL_W]),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .result     (result)
   );

   assign done_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (done_valid && done_ready) begin
         rsp_data_in  = result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.status;
   assign rsp_tdata  = {{pl_pkg::RSP_PAD_W{1'b0}},
                        rsp_data_ff.list_size,
                        rsp_data_ff.found_index,
                        rsp_data_ff.read_value};

endmodule

// File: src/pl_checker.sv
// Port-level checks for positional_list_engine, attached by bind.
// Uses pl_pkg for the field widths and the capacity.
module pl_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic                           rsp_tuser,
   input logic [pl_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int FOUND_LO = pl_pkg::VAL_W;
   localparam int SIZE_LO  = pl_pkg::VAL_W + pl_pkg::FIND_W;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response word changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response word present right after reset");

   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one still in work");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         (rsp_tdata[SIZE_LO +: pl_pkg::SIZE_W] <= pl_pkg::SIZE_W'(pl_pkg::CAPACITY)))
      else $error("list size beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[FOUND_LO +: pl_pkg::FIND_W] == '0)
      else $error("failed request reports a found index");

endmodule

bind positional_list_engine pl_checker u_pl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// File: sim/positional_list_checker.sv
// Checker for the positional list engine: watches both stream channels, keeps
// its own copy of the list to predict each response word, and compares.
// Depends on pl_pkg for widths, the kind codes and the response layout.
`timescale 1ns / 1ps

module positional_list_checker
   import pl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [KIND_W-1:0]      req_tuser,  // kind
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // position, value, zero pad
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   rsp_tuser,  // status
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,  // read_value, found_index, list_size, pad
   output int                     mismatch_count,
   output int                     pending_count,
   output int                     words_checked,
   output int                     fail_words,
   output int                     list_length,
   output int                     peak_length
);

   localparam logic [FIND_W-1:0] NO_MATCH    = '1;
   localparam logic [VAL_W-1:0]  FAILED_READ = '1;
   localparam int                MAX_REPORTS = 40;

   word_type   list_words [CAPACITY];
   int         held_count;
   result_type outstanding [$];

   task automatic report_mismatch(input string what, input logic [63:0] want_v,
                                  input logic [63:0] got_v);
      if (mismatch_count < MAX_REPORTS)
         $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want_v,
                  got_v);
      mismatch_count++;
   endtask

   // Apply one request to the list copy and return the response it must give.
   function automatic result_type apply_list_op(input logic [KIND_W-1:0] kind,
                                                input logic signed [POS_W-1:0] pos,
                                                input logic [VAL_W-1:0] value);
      result_type res;
      word_type   w;
      int         p;
      int         i;
      logic       in_list;
      res     = '0;
      w       = word_type'(signed'(value));
      p       = pos;
      in_list = (p >= 0) && (p < held_count);
      case (kind)
         KIND_INSERT: begin
            if (held_count >= CAPACITY || p < -1 || p > held_count) begin
               res.status = 1'b1;
            end else begin
               if (p == -1) p = held_count;
               for (i = held_count; i > p; i--) list_words[i] = list_words[i-1];
               list_words[p] = w;
               held_count++;
            end
         end
         KIND_DELETE: begin
            if (!in_list) begin
               res.status = 1'b1;
            end else begin
               for (i = p; i + 1 < held_count; i++) list_words[i] = list_words[i+1];
               held_count--;
            end
         end
         KIND_OVERWRITE: begin
            if (!in_list) res.status = 1'b1;
            else list_words[p] = w;
         end
         KIND_READ: begin
            if (!in_list) begin
               res.status     = 1'b1;
               res.read_value = FAILED_READ;
            end else begin
               res.read_value = VAL_W'(signed'(list_words[p]));
            end
         end
         KIND_FIND: begin
            res.found_index = NO_MATCH;
            for (i = 0; i < held_count; i++)
               if (res.found_index == NO_MATCH && list_words[i] == w)
                  res.found_index = FIND_W'(i);
         end
         KIND_CLEAR: begin
            held_count = 0;
         end
         default: begin
            res.status = 1'b1;
         end
      endcase
      res.list_size = SIZE_W'(held_count);
      return res;
   endfunction

   initial begin
      mismatch_count = 0;
      words_checked  = 0;
      fail_words     = 0;
      peak_length    = 0;
      pending_count  = 0;
      list_length    = 0;
      held_count     = 0;
   end

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         held_count = 0;
         outstanding.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status      = rsp_tuser;
            got.read_value  = rsp_tdata[VAL_W-1:0];
            got.found_index = rsp_tdata[VAL_W +: FIND_W];
            got.list_size   = rsp_tdata[VAL_W+FIND_W +: SIZE_W];
            if (outstanding.size() == 0) begin
               report_mismatch("unexpected response word", '0, got);
            end else begin
               want = outstanding.pop_front();
               words_checked++;
               if (got.status === 1'b1) fail_words++;
               if (got.status !== want.status)
                  report_mismatch("status", want.status, got.status);
               if (got.read_value !== want.read_value)
                  report_mismatch("read_value", want.read_value, got.read_value);
               if (got.found_index !== want.found_index)
                  report_mismatch("found_index", want.found_index, got.found_index);
               if (got.list_size !== want.list_size)
                  report_mismatch("list_size", want.list_size, got.list_size);
            end
         end
         if (req_tvalid && req_tready)
            outstanding.push_back(apply_list_op(req_tuser, req_tdata[POS_W-1:0],
                                                req_tdata[POS_W +: VAL_W]));
      end
      pending_count = outstanding.size();
      list_length   = held_count;
      if (held_count > peak_length) peak_length = held_count;
   end

endmodule

// File: sim/positional_list_engine_tb.sv
// Testbench top for the positional list engine: clock, reset, request and
// response stream drivers, and the verdict. Depends on pl_pkg, the block
// positional_list_engine and positional_list_checker.
`timescale 1ns / 1ps

module positional_list_engine_tb;
   import pl_pkg::*;

   localparam int RANDOM_WORDS = 1050;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 200;
   localparam int STEADY_FROM  = 500;
   localparam int STEADY_TO    = 650;
   localparam int IDLE_PCT     = 19;
   localparam logic [KIND_W-1:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [KIND_W-1:0] KIND_UNUSED_7 = 3'd7;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [KIND_W-1:0]      req_tuser  = '0;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   rsp_tuser;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int   mismatch_count;
   int   pending_count;
   int   words_checked;
   int   fail_words;
   int   list_length;
   int   peak_length;
   int   sent_count    = 0;
   int   ignored_count = 0;
   logic steady        = 1'b0;
   logic filling       = 1'b1;

   logic [VAL_W-1:0] value_pool [8] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                        32'h7FFF_FFFF, 32'h8000_0000, 32'h5A5A_5A5A,
                                        32'hA5A5_A5A5, 32'h0001_0000};

   always #1 clock = ~clock;

   positional_list_engine i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

   positional_list_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tuser      (req_tuser),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tuser      (rsp_tuser),
      .rsp_tdata      (rsp_tdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .words_checked  (words_checked),
      .fail_words     (fail_words),
      .list_length    (list_length),
      .peak_length    (peak_length)
   );

   // Offer one request word and hold it until accepted; entered and left at a falling edge.
   task automatic send_request(input logic [KIND_W-1:0] kind,
                               input logic signed [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] value);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {{(REQ_TDATA_W-POS_W-VAL_W){1'b0}}, value, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      sent_count++;
      if (kind == KIND_UNUSED_6 || kind == KIND_UNUSED_7) ignored_count++;
   endtask

   task automatic send_random_request();
      int               roll;
      int               len;
      int               p;
      logic [KIND_W-1:0] kind;
      logic [VAL_W-1:0] value;
      len  = list_length;
      if (len == 0) filling = 1'b1;
      if (len == CAPACITY && $urandom_range(3) == 0) filling = 1'b0;
      roll = $urandom_range(99);
      if (roll < (filling ? 32 : 14))  kind = KIND_INSERT;
      else if (roll < 44)              kind = KIND_DELETE;
      else if (roll < 56)              kind = KIND_OVERWRITE;
      else if (roll < 74)              kind = KIND_READ;
      else if (roll < 96)              kind = KIND_FIND;
      else if (roll < 97)              kind = KIND_CLEAR;
      else                             kind = $urandom_range(1) ? KIND_UNUSED_7 : KIND_UNUSED_6;
      if ($urandom_range(99) < 15 || kind == KIND_FIND || kind == KIND_CLEAR)
         p = $urandom_range(127) - 64;
      else if (kind == KIND_INSERT)
         p = ($urandom_range(4) == 0) ? -1 : $urandom_range(len);
      else
         p = (len == 0) ? 0 : $urandom_range(len - 1);
      value = ($urandom_range(99) < 45) ? value_pool[$urandom_range(7)] : $urandom;
      send_request(kind, p, value);
   endtask

   initial begin
      #1_000_000;
      $display("timeout with %0d response words still outstanding", pending_count);
      $display("== FAIL ==");
      $finish;
   end

   // Response side: random stalls, one long hold-off, and a stall-free window.
   initial begin
      logic held;
      held = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && sent_count >= HOLD_AT) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   initial begin
      int random_sent;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(KIND_READ,      0,   32'h0);
      send_request(KIND_DELETE,    0,   32'h0);
      send_request(KIND_OVERWRITE, 0,   32'h1);
      send_request(KIND_FIND,      0,   32'h0);
      send_request(KIND_INSERT,    1,   32'h1);
      send_request(KIND_INSERT,    -2,  32'h1);
      send_request(KIND_INSERT,    -1,  32'h7FFF_FFFF);
      send_request(KIND_INSERT,    0,   32'h8000_0000);
      send_request(KIND_INSERT,    2,   32'hFFFF_FFFF);
      send_request(KIND_INSERT,    -64, 32'h0);
      send_request(KIND_INSERT,    63,  32'h0);
      send_request(KIND_READ,      63,  32'h0);
      send_request(KIND_READ,      0,   32'h0);
      send_request(KIND_READ,      -1,  32'h0);
      send_request(KIND_OVERWRITE, 1,   32'h0);
      send_request(KIND_OVERWRITE, 3,   32'h1);
      send_request(KIND_FIND,      -1,  32'hFFFF_FFFF);
      send_request(KIND_FIND,      63,  32'h1234_5678);
      send_request(KIND_DELETE,    1,   32'h0);
      send_request(KIND_DELETE,    5,   32'h0);
      send_request(KIND_READ,      1,   32'h0);
      send_request(KIND_UNUSED_6,  0,   32'hFFFF_FFFF);
      send_request(KIND_UNUSED_7,  -1,  32'h0);
      send_request(KIND_CLEAR,     0,   32'h0);
      send_request(KIND_READ,      0,   32'h0);

      random_sent = 0;
      while (random_sent < RANDOM_WORDS) begin
         steady = (random_sent >= STEADY_FROM && random_sent < STEADY_TO);
         send_random_request();
         if (req_tuser != KIND_UNUSED_6 && req_tuser != KIND_UNUSED_7) random_sent++;
      end
      steady = 1'b0;
      req_tvalid <= 1'b0;

      wait (pending_count == 0);
      repeat (CAPACITY + 16) @(negedge clock);

      $display("Sent %0d requests (%0d with unused kind codes); checked %0d responses, %0d failed.",
               sent_count, ignored_count, words_checked, fail_words);
      $display("List grew to %0d of %0d entries; one %0d-cycle response hold-off.",
               peak_length, CAPACITY, HOLD_CYCLES);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
